// File: design/sbb_pkg.sv
// Package: constants and types for the sprite batch builder.
`default_nettype none
package sbb_pkg;
	localparam int MaxQuads = 10;
	localparam int MaxSlots = 32;
	localparam int SlotW    = 6;
	localparam int IdxW     = $clog2(MaxSlots);
	localparam int QuadW    = 4;
	localparam int NCell    = MaxSlots - 1;

	localparam logic [1:0] KIND_VERT  = 2'd0;
	localparam logic [1:0] KIND_BIND  = 2'd1;
	localparam logic [1:0] KIND_FLUSH = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SEARCH, ST_DECIDE, ST_BIND, ST_VERT
	} state_t;

	// search pulse handed down the cell chain
	typedef struct packed {
		logic             valid;
		logic             hit;
		logic [IdxW-1:0]  hit_idx;
	} probe_t;

	function automatic logic [15:0] sat16(input logic signed [16:0] v);
		logic [15:0] r;
		if (v > 17'sd32767) r = 16'h7FFF;
		else if (v < -17'sd32768) r = 16'h8000;
		else r = v[15:0];
		return r;
	endfunction
endpackage
`default_nettype wire

// File: design/sbb_cell.sv
// One slot cell: holds a texture id and compares it as the search probe passes.
`default_nettype none
module sbb_cell import sbb_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [IdxW-1:0]   my_idx,
	input  wire logic              wr_en,
	input  wire logic [31:0]       wr_id,
	input  wire logic [31:0]       key,
	input  wire logic [SlotW-1:0]  used,
	input  wire probe_t            probe_in,
	output probe_t                 probe_out
);
	logic [31:0] id_q;
	logic        match;

	always_ff @(posedge clk) begin
		if (wr_en) id_q <= wr_id;
	end

	assign match = probe_in.valid && !probe_in.hit &&
		({1'b0, my_idx} < used) && (id_q == key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_out <= '0;
		end else begin
			probe_out.valid   <= probe_in.valid;
			probe_out.hit     <= probe_in.hit | match;
			probe_out.hit_idx <= match ? my_idx : probe_in.hit_idx;
		end
	end
endmodule
`default_nettype wire

// File: design/sprite_batch_builder.sv
// Top level: sequencer, slot cell chain and result register.
`default_nettype none
// A request (start while busy is low) yields 1 to 6 results, one per cycle on
// the strobe; the receiver cannot stall. A draw keeps busy high until it is
// through its steps, so no new request is taken before then: it launches the
// texture probe, the probe walks the 31 slot cells, then come a decide step,
// an optional bind step and four vertex steps.
// A flush goes out in a cycle the sequence spends anyway. End of frame keeps
// busy low; its flush strobes in the next cycle.
module sprite_batch_builder import sbb_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [31:0]        cfg_wdata,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               req_type,
	input  wire logic [31:0]        tex_id,
	input  wire logic signed [15:0] pos_x,
	input  wire logic signed [15:0] pos_y,
	input  wire logic signed [15:0] size_x,
	input  wire logic signed [15:0] size_y,
	input  wire logic [15:0]        tex_s_start,
	input  wire logic [15:0]        tex_t_start,
	input  wire logic [15:0]        tex_s_end,
	input  wire logic [15:0]        tex_t_end,
	input  wire logic [31:0]        color_rgba,
	output logic                    strobe,
	output logic [1:0]              kind,
	output logic signed [15:0]      vert_x,
	output logic signed [15:0]      vert_y,
	output logic [15:0]             vert_s,
	output logic [15:0]             vert_t,
	output logic [31:0]             vert_color,
	output logic [SlotW-1:0]        slot,
	output logic [31:0]             value,
	output logic                    last
);
	state_t state_q, state_n;
	logic [31:0] white_q, tex_q, col_q;
	logic [15:0] x0_q, x1_q, y0_q, y1_q, s0_q, s1_q, t0_q, t1_q;
	logic [SlotW-1:0] used_q;
	logic [QuadW-1:0] quads_q;
	logic [1:0] vcnt_q;
	logic [IdxW-1:0] slot_q;
	logic need_bind_q;
	logic launch_q;

	probe_t probe_launch;
	probe_t chain [NCell+1];
	logic [NCell-1:0] wr_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) white_q <= '0;
		else if (cfg_we) white_q <= cfg_wdata;
	end

	wire accept = start && (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE);

	// probe starts once the request's texture id sits in tex_q
	always_comb begin
		probe_launch = '0;
		probe_launch.valid = launch_q;
		probe_launch.hit   = launch_q && (tex_q == white_q);
	end
	assign chain[0] = probe_launch;

	genvar g;
	generate
		for (g = 0; g < NCell; g++) begin : g_cell
			assign wr_sel[g] = (state_q == ST_BIND) &&
				(slot_q == IdxW'(g + 1));
			sbb_cell u_cell (
				.clk(clk), .arst_n(arst_n), .my_idx(IdxW'(g + 1)),
				.wr_en(wr_sel[g]), .wr_id(tex_q),
				.key(tex_q), .used(used_q),
				.probe_in(chain[g]), .probe_out(chain[g+1])
			);
		end
	endgenerate

	wire probe_done = chain[NCell].valid;
	wire batch_full = ({2'b0, quads_q} >= (QuadW+2)'(MaxQuads));

	// sequencing step in DECIDE: flush first if slots full on miss (a quads-full flush goes out as the search ends)
	logic [SlotW-1:0] used_eff;
	always_comb used_eff = batch_full ? SlotW'(1) : used_q;

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE:   if (accept) state_n = req_type ? ST_IDLE : ST_SEARCH;
			ST_SEARCH: if (probe_done) state_n = ST_DECIDE;
			ST_DECIDE: state_n = need_bind_q ? ST_BIND : ST_VERT;
			ST_BIND:   state_n = ST_VERT;
			ST_VERT:   if (vcnt_q == 2'd3) state_n = ST_IDLE;
			default:   state_n = ST_IDLE;
		endcase
	end

	// search is run against the pre-flush table; a quad-count flush empties it
	logic hit_eff;
	always_comb hit_eff = chain[NCell].hit && !(batch_full && chain[NCell].hit_idx != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			used_q  <= SlotW'(1);
			quads_q <= '0;
			vcnt_q  <= '0;
			slot_q  <= '0;
			need_bind_q <= 1'b0;
			launch_q <= 1'b0;
			strobe  <= 1'b0;
		end else begin
			state_q <= state_n;
			launch_q <= accept && !req_type;
			strobe  <= 1'b0;
			if (accept && req_type) begin
				strobe <= 1'b1;
				used_q <= SlotW'(1);
				quads_q <= '0;
			end
			if (state_q == ST_SEARCH && probe_done) begin
				need_bind_q <= !hit_eff;
				slot_q <= chain[NCell].hit_idx;
				if (batch_full) begin
					strobe <= 1'b1;
					used_q <= SlotW'(1);
					quads_q <= '0;
				end
			end
			if (state_q == ST_DECIDE && need_bind_q) begin
				if ({1'b0, used_eff} >= (SlotW+1)'(MaxSlots)) begin
					strobe <= 1'b1;
					slot_q <= IdxW'(1);
					used_q <= SlotW'(2);
					quads_q <= '0;
				end else begin
					slot_q <= used_q[IdxW-1:0];
					used_q <= used_q + SlotW'(1);
				end
			end
			if (state_q == ST_BIND) strobe <= 1'b1;
			if (state_q == ST_VERT) begin
				strobe <= 1'b1;
				vcnt_q <= vcnt_q + 2'd1;
				if (vcnt_q == 2'd3) quads_q <= quads_q + QuadW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tex_q <= tex_id;
			col_q <= color_rgba;
			x0_q <= sat16(17'(pos_x));
			y0_q <= sat16(17'(pos_y));
			x1_q <= sat16(17'(pos_x) + 17'(size_x));
			y1_q <= sat16(17'(pos_y) + 17'(size_y));
			s0_q <= tex_s_start; s1_q <= tex_s_end;
			t0_q <= tex_t_start; t1_q <= tex_t_end;
		end
		kind <= KIND_FLUSH; vert_x <= '0; vert_y <= '0; vert_s <= '0;
		vert_t <= '0; vert_color <= '0; value <= '0; last <= 1'b0;
		slot <= used_q;
		if (accept && req_type) begin
			value <= 32'(quads_q); last <= 1'b1;
		end else if (state_q == ST_SEARCH) begin
			value <= 32'(quads_q);
		end else if (state_q == ST_DECIDE) begin
			value <= 32'(quads_q);
			slot  <= used_eff;
		end else if (state_q == ST_BIND) begin
			kind <= KIND_BIND; slot <= SlotW'(slot_q); value <= tex_q;
		end else if (state_q == ST_VERT) begin
			kind <= KIND_VERT; slot <= SlotW'(slot_q); vert_color <= col_q;
			vert_x <= (vcnt_q == 2'd0 || vcnt_q == 2'd3) ? x0_q : x1_q;
			vert_y <= (vcnt_q[1]) ? y1_q : y0_q;
			vert_s <= (vcnt_q == 2'd0 || vcnt_q == 2'd3) ? s0_q : s1_q;
			vert_t <= (vcnt_q[1]) ? t1_q : t0_q;
			last   <= (vcnt_q == 2'd3);
		end
	end

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && !start) |=> !strobe) else $error("spurious strobe");
	a_used_min: assert property (@(posedge clk) disable iff (!arst_n)
		used_q != '0) else $error("slot count zero");
	a_vert_after_bind: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BIND |=> state_q == ST_VERT) else $error("bind not followed");
endmodule
`default_nettype wire
